// ----- src/tfr_pkg.sv -----
`timescale 1ns / 1ps

package tfr_pkg;

  // Source format codes as held in the configuration register
  typedef enum logic [3:0] {
    FMT_RGB888   = 4'd0,
    FMT_BGR888   = 4'd1,
    FMT_ABGR8888 = 4'd2,
    FMT_BGRA8888 = 4'd3,
    FMT_LA88     = 4'd4,
    FMT_L8       = 4'd5,
    FMT_X1RGB555 = 4'd6,
    FMT_RGB565   = 4'd7,
    FMT_RGBA8888 = 4'd8
  } fmt_e;

  localparam int unsigned FmtWidth   = 4;
  localparam int unsigned PixelWidth = 32;
  localparam int unsigned ChanWidth  = 8;

  typedef logic [PixelWidth-1:0] pixel_t;
  typedef logic [ChanWidth-1:0]  chan_t;

  // One converted pixel
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  unsupported;
  } rgb_t;

endpackage

// ----- src/tfr_cfg_if.sv -----
`timescale 1ns / 1ps

interface tfr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tfr_pkg::FmtWidth-1:0]       source_format;

  modport source (output valid, output source_format, input ready);
  modport sink   (input valid, input source_format, output ready);
endinterface

// ----- src/tfr_pix_if.sv -----
`timescale 1ns / 1ps

interface tfr_pix_if;
  logic            valid;
  logic            ready;
  tfr_pkg::pixel_t pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

// ----- src/tfr_rgb_if.sv -----
`timescale 1ns / 1ps

interface tfr_rgb_if;
  logic           valid;
  logic           ready;
  tfr_pkg::chan_t red;
  tfr_pkg::chan_t green;
  tfr_pkg::chan_t blue;
  logic           unsupported;

  modport source (output valid, output red, output green, output blue,
                  output unsupported, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input unsupported, output ready);
endinterface

// ----- src/tfr_convert.sv -----
`timescale 1ns / 1ps

module tfr_convert (
  input  logic [tfr_pkg::FmtWidth-1:0] fmt_i,
  input  tfr_pkg::pixel_t              pixel_i,
  output tfr_pkg::rgb_t                rgb_o
);

  // c*a/255 truncated, exact for every 8-bit c and a: (p + (p>>8) + 1) >> 8
  function automatic tfr_pkg::chan_t premul(input tfr_pkg::chan_t c,
                                            input tfr_pkg::chan_t a);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = 16'(c) * 16'(a);
    sum  = prod + {8'd0, prod[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

  tfr_pkg::chan_t b0, b1, b2, b3;
  tfr_pkg::chan_t pm_r, pm_g, pm_b, pm_a;
  tfr_pkg::chan_t mul_r, mul_g, mul_b;

  assign b0 = pixel_i[7:0];
  assign b1 = pixel_i[15:8];
  assign b2 = pixel_i[23:16];
  assign b3 = pixel_i[31:24];

  // Pick premultiply operands first so only three multipliers are needed
  always_comb begin
    pm_r = b3;
    pm_g = b2;
    pm_b = b1;
    pm_a = b0;
    if (fmt_i == tfr_pkg::FMT_BGRA8888) begin
      pm_r = b2;
      pm_g = b1;
      pm_b = b0;
      pm_a = b3;
    end else if (fmt_i == tfr_pkg::FMT_LA88) begin
      pm_r = b0;
      pm_g = b0;
      pm_b = b0;
      pm_a = b1;
    end
  end

  assign mul_r = premul(pm_r, pm_a);
  assign mul_g = premul(pm_g, pm_a);
  assign mul_b = premul(pm_b, pm_a);

  always_comb begin
    rgb_o = '0;
    unique case (fmt_i)
      tfr_pkg::FMT_RGB888: begin
        rgb_o.red   = b0;
        rgb_o.green = b1;
        rgb_o.blue  = b2;
      end
      tfr_pkg::FMT_BGR888: begin
        rgb_o.red   = b2;
        rgb_o.green = b1;
        rgb_o.blue  = b0;
      end
      tfr_pkg::FMT_ABGR8888, tfr_pkg::FMT_BGRA8888, tfr_pkg::FMT_LA88: begin
        rgb_o.red   = mul_r;
        rgb_o.green = mul_g;
        rgb_o.blue  = mul_b;
      end
      tfr_pkg::FMT_L8: begin
        rgb_o.red   = b0;
        rgb_o.green = b0;
        rgb_o.blue  = b0;
      end
      tfr_pkg::FMT_X1RGB555: begin
        rgb_o.red   = {pixel_i[14:10], 3'b000};
        rgb_o.green = {pixel_i[9:5], 3'b000};
        rgb_o.blue  = {pixel_i[4:0], 3'b000};
      end
      tfr_pkg::FMT_RGB565: begin
        rgb_o.red   = {pixel_i[15:11], 3'b000};
        rgb_o.green = {pixel_i[10:5], 2'b00};
        rgb_o.blue  = {pixel_i[4:0], 3'b000};
      end
      default: begin
        rgb_o.unsupported = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/texel_format_to_rgb888_top.sv -----
`timescale 1ns / 1ps

// Source pixel to RGB888 converter.
//
// pix_i carries one source pixel word per item (first source byte in bits
// 7:0, 16-bit formats in bits 15:0); rgb_o gives one RGB888 item per input
// item, with the unsupported flag set and zero color for formats that cannot
// be converted. cfg_i writes the source format; its ready is always high.
// Write the format only while no items are in flight.
//
// An item accepted on pix_i lands in the input register, moves into the result
// register once that register is free, and is presented on rgb_o from then on.
// Throughput is one item per cycle while the receiver does not stall; the
// premultiply path (8x8 multiply plus the /255 add-and-shift) sits between the
// two registers and sets the clock period.
// Reset clears both stages and sets the format to RGB888. When the receiver
// stalls, the result register holds its item and the input register still
// takes one more; pix_i.ready drops only once both stages are full, and
// comes back in the cycle the receiver takes the result.
module texel_format_to_rgb888_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  tfr_cfg_if.sink          cfg_i,
  tfr_pix_if.sink          pix_i,
  tfr_rgb_if.source        rgb_o
);

  logic [tfr_pkg::FmtWidth-1:0] fmt_q;

  logic            in_valid_q;
  tfr_pkg::pixel_t pixel_q;
  logic            out_valid_q;
  tfr_pkg::rgb_t   rgb_q;
  tfr_pkg::rgb_t   rgb_d;

  logic out_free;
  logic in_adv;
  logic in_accept;

  // Format register: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tfr_pkg::FMT_RGB888;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.source_format;
    end
  end

  // Handshake chain: result register frees when empty or taken
  assign out_free    = !out_valid_q || rgb_o.ready;
  assign in_adv      = in_valid_q && out_free;
  assign pix_i.ready = !in_valid_q || out_free;
  assign in_accept   = pix_i.valid && pix_i.ready;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pixel_q <= pix_i.pixel_word;
    end
  end

  tfr_convert u_convert (
    .fmt_i   (fmt_q),
    .pixel_i (pixel_q),
    .rgb_o   (rgb_d)
  );

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o.valid       = out_valid_q;
  assign rgb_o.red         = rgb_q.red;
  assign rgb_o.green       = rgb_q.green;
  assign rgb_o.blue        = rgb_q.blue;
  assign rgb_o.unsupported = rgb_q.unsupported;

  // Unsupported results never carry color
  a_unsupported_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rgb_q.unsupported |->
      rgb_q.red == '0 && rgb_q.green == '0 && rgb_q.blue == '0)
    else $error("unsupported result with nonzero color");

  // A blocked input stage keeps its item
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(pixel_q))
    else $error("input stage lost an item while blocked");

  // A result only appears if the input stage held an item
  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !in_valid_q |=> !out_valid_q)
    else $error("result appeared without a source item");

  // An accepted item always lands in the input stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted item not captured");

endmodule
